[rtl/djs_pkg.sv]
// Shared types and op codes for the deadline job selector.
`default_nettype none
package djs_pkg;
  localparam int unsigned ValW = 31;

  typedef struct packed {
    logic            vld;
    logic [ValW-1:0] dl;
    logic [ValW-1:0] du;
  } job_t;

  typedef struct packed {
    logic            vld;
    logic [ValW-1:0] du;
  } heap_ent_t;

  typedef enum logic [1:0] {
    SORT_HOLD   = 2'd0,
    SORT_INSERT = 2'd1,
    SORT_POP    = 2'd2
  } sort_op_t;

  typedef enum logic [1:0] {
    HEAP_HOLD    = 2'd0,
    HEAP_INSERT  = 2'd1,
    HEAP_REPLACE = 2'd2,
    HEAP_CLEAR   = 2'd3
  } heap_op_t;
endpackage
`default_nettype wire

[rtl/djs_sort_cell.sv]
// One cell of the deadline-ordered job chain.
`default_nettype none
module djs_sort_cell import djs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire sort_op_t op,
  input  wire job_t     new_job,
  input  wire job_t     left,
  input  wire job_t     right,
  output job_t          cur
);
  job_t cur_next;
  logic self_le, left_le;

  assign self_le = cur.vld && (cur.dl <= new_job.dl);
  assign left_le = left.vld && (left.dl <= new_job.dl);

  always_comb begin
    cur_next = cur;
    unique case (op)
      SORT_INSERT: begin
        if (self_le) cur_next = cur;
        else if (left_le) cur_next = new_job;
        else cur_next = left;
      end
      SORT_POP: cur_next = right;
      default: cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else begin
      cur.vld <= cur_next.vld;
    end
    cur.dl <= cur_next.dl;
    cur.du <= cur_next.du;
  end
endmodule
`default_nettype wire

[rtl/djs_heap_cell.sv]
// One cell of the descending chain of accepted durations.
`default_nettype none
module djs_heap_cell import djs_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire heap_op_t        op,
  input  wire logic [ValW-1:0] du_new,
  input  wire heap_ent_t       left,
  input  wire heap_ent_t       right,
  output heap_ent_t            cur
);
  heap_ent_t cur_next;
  heap_ent_t ins;
  logic self_ge, left_ge, right_ge;

  assign self_ge  = cur.vld && (cur.du >= du_new);
  assign left_ge  = left.vld && (left.du >= du_new);
  assign right_ge = right.vld && (right.du >= du_new);
  assign ins      = '{vld: 1'b1, du: du_new};

  always_comb begin
    cur_next = cur;
    unique case (op)
      HEAP_INSERT: begin
        if (self_ge) cur_next = cur;
        else if (left_ge) cur_next = ins;
        else cur_next = left;
      end
      HEAP_REPLACE: begin
        if (right_ge) cur_next = right;
        else if (self_ge) cur_next = ins;
        else cur_next = cur;
      end
      HEAP_CLEAR: cur_next = '{vld: 1'b0, du: cur.du};
      default: cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else begin
      cur.vld <= cur_next.vld;
    end
    cur.du <= cur_next.du;
  end
endmodule
`default_nettype wire

[rtl/deadline_job_selector_unit.sv]
// Top level: job loading, deadline sort chain, accepted-duration chain, result.
//
//  channel | signals                               | dir
//  in      | in_valid in_ready duration deadline last_job | in
//  out     | out_valid out_ready jobs_done overflowed      | out
//
// Loading takes one cycle per job, inserted in deadline order along the cell row.
// After the last job, evaluation pops one job per cycle until the row is empty,
// then moves to the output state.
// The result then waits in the output register; no input is taken until it goes.
// rst clears all control state and cell valid bits.
`default_nettype none
module deadline_job_selector_unit import djs_pkg::*; #(
  parameter int unsigned MAX_JOBS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [ValW-1:0] duration,
  input  wire logic [ValW-1:0] deadline,
  input  wire logic            last_job,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [10:0]          jobs_done,
  output logic                 overflowed
);
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_EVAL = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] loaded, loaded_next;
  logic [CW-1:0] remain, remain_next;
  logic [CW-1:0] hcount, hcount_next;
  logic [ValW-1:0] elapsed, elapsed_next;
  logic          ovf, ovf_next;

  sort_op_t  sop;
  heap_op_t  hop;
  job_t      new_job;
  job_t      sc [MAX_JOBS];
  heap_ent_t hc [MAX_JOBS];
  job_t      head;
  heap_ent_t top;
  logic      in_acc, full, fit, repl;
  logic [ValW:0] sum, rsum;
  logic [CW+10:0] cnt_ext;

  assign in_ready = (state == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = (loaded == CW'(MAX_JOBS));
  assign new_job  = '{vld: 1'b1, dl: deadline, du: duration};
  assign head     = sc[0];
  assign top      = hc[0];

  assign sum  = {1'b0, elapsed} + {1'b0, head.du};
  assign fit  = (sum <= {1'b0, head.dl});
  assign rsum = {1'b0, elapsed} - {1'b0, top.du} + {1'b0, head.du};
  assign repl = (hcount != '0) && (top.du > head.du) && (rsum <= {1'b0, head.dl});

  genvar g;
  generate
    for (g = 0; g < MAX_JOBS; g++) begin : g_cells
      job_t      sl, sr;
      heap_ent_t hl, hr;
      if (g == 0) begin : g_first
        assign sl = '{vld: 1'b1, dl: '0, du: '0};
        assign hl = '{vld: 1'b1, du: '1};
      end else begin : g_mid_l
        assign sl = sc[g-1];
        assign hl = hc[g-1];
      end
      if (g == MAX_JOBS - 1) begin : g_last
        assign sr = '{vld: 1'b0, dl: '0, du: '0};
        assign hr = '{vld: 1'b0, du: '0};
      end else begin : g_mid_r
        assign sr = sc[g+1];
        assign hr = hc[g+1];
      end
      djs_sort_cell u_sort (
        .clk(clk), .rst(rst), .op(sop), .new_job(new_job),
        .left(sl), .right(sr), .cur(sc[g])
      );
      djs_heap_cell u_heap (
        .clk(clk), .rst(rst), .op(hop), .du_new(head.du),
        .left(hl), .right(hr), .cur(hc[g])
      );
    end
  endgenerate

  always_comb begin
    state_next   = state;
    loaded_next  = loaded;
    remain_next  = remain;
    hcount_next  = hcount;
    elapsed_next = elapsed;
    ovf_next     = ovf;
    sop          = SORT_HOLD;
    hop          = HEAP_HOLD;
    unique case (state)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            sop         = SORT_INSERT;
            loaded_next = loaded + CW'(1);
          end
          if (last_job) begin
            remain_next = full ? loaded : loaded + CW'(1);
            state_next  = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (remain == '0) begin
          state_next = ST_OUT;
        end else begin
          sop         = SORT_POP;
          remain_next = remain - CW'(1);
          if (fit) begin
            hop          = HEAP_INSERT;
            hcount_next  = hcount + CW'(1);
            elapsed_next = sum[ValW-1:0];
          end else if (repl) begin
            hop          = HEAP_REPLACE;
            elapsed_next = rsum[ValW-1:0];
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          hop          = HEAP_CLEAR;
          hcount_next  = '0;
          loaded_next  = '0;
          elapsed_next = '0;
          ovf_next     = 1'b0;
          state_next   = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      loaded  <= '0;
      remain  <= '0;
      hcount  <= '0;
      elapsed <= '0;
      ovf     <= 1'b0;
    end else begin
      state   <= state_next;
      loaded  <= loaded_next;
      remain  <= remain_next;
      hcount  <= hcount_next;
      elapsed <= elapsed_next;
      ovf     <= ovf_next;
    end
  end

  assign cnt_ext    = {11'b0, hcount};
  assign out_valid  = (state == ST_OUT);
  assign jobs_done  = cnt_ext[10:0];
  assign overflowed = ovf;
endmodule
`default_nettype wire

[test/deadline_job_selector_unit_tb.sv]
// Testbench for the deadline job selector: directed and random batches checked against a scheduling model.
`default_nettype none
module deadline_job_selector_unit_tb;
  import djs_pkg::*;

  localparam int unsigned Cap = 1024;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [ValW-1:0] du;
    logic [ValW-1:0] dl;
    logic            last;
  } word_t;

  typedef struct packed {
    logic [10:0] done;
    logic        ovf;
  } tally_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [ValW-1:0] duration = '0;
  logic [ValW-1:0] deadline = '0;
  logic            last_job = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [10:0]     jobs_done;
  logic            overflowed;

  word_t  pending_words[$];
  tally_t expected_tallies[$];
  int     errors = 0;
  int     cycles = 0;
  bit     stim_done = 1'b0;
  bit     calm = 1'b0;
  int     hold_off = 0;

  logic [ValW-1:0] batch_du[$];
  logic [ValW-1:0] batch_dl[$];
  bit              batch_ovf = 1'b0;

  deadline_job_selector_unit dut (.*);

  always #10 clk = ~clk;

  // Moore-Hodgson over the collected batch: stable sort, max-heap kept as a sorted queue
  function automatic logic [10:0] max_on_time(input logic [ValW-1:0] du[$],
                                              input logic [ValW-1:0] dl[$]);
    logic [ValW-1:0] sdu[$];
    logic [ValW-1:0] sdl[$];
    logic [ValW-1:0] kept[$];
    logic [63:0]     spent;
    int              p;
    sdu = du;
    sdl = dl;
    for (int k = 1; k < sdl.size(); k++) begin
      logic [ValW-1:0] a, b;
      a = sdl[k];
      b = sdu[k];
      p = k;
      while (p > 0 && sdl[p-1] > a) begin
        sdl[p] = sdl[p-1];
        sdu[p] = sdu[p-1];
        p--;
      end
      sdl[p] = a;
      sdu[p] = b;
    end
    spent = 0;
    for (int k = 0; k < sdl.size(); k++) begin
      if (spent + sdu[k] <= sdl[k]) begin
        spent += sdu[k];
        kept.push_back(sdu[k]);
        kept.sort();
      end else if (kept.size() > 0) begin
        if (kept[kept.size()-1] > sdu[k] &&
            spent - kept[kept.size()-1] + sdu[k] <= sdl[k]) begin
          spent = spent - kept[kept.size()-1] + sdu[k];
          kept[kept.size()-1] = sdu[k];
          kept.sort();
        end
      end
    end
    return 11'(kept.size());
  endfunction

  function automatic void record_job(input word_t w);
    tally_t t;
    if (batch_du.size() < Cap) begin
      batch_du.push_back(w.du);
      batch_dl.push_back(w.dl);
    end else begin
      batch_ovf = 1'b1;
    end
    if (w.last) begin
      t.done = max_on_time(batch_du, batch_dl);
      t.ovf = batch_ovf;
      expected_tallies.push_back(t);
      batch_du.delete();
      batch_dl.delete();
      batch_ovf = 1'b0;
    end
  endfunction

  function automatic logic [ValW-1:0] rnd_val(input int mode);
    case (mode)
      0: return 31'($urandom_range(0, 20));
      1: return 31'($urandom_range(0, 200));
      2: return 31'($urandom);
      default: return 31'(32'h7fffffff - $urandom_range(0, 50));
    endcase
  endfunction

  task automatic add_batch(input int n, input int mode);
    word_t w;
    for (int k = 0; k < n; k++) begin
      w.du = rnd_val(mode);
      w.dl = (mode < 2) ? 31'(rnd_val(mode) * 3) : rnd_val(mode);
      w.last = (k == n - 1);
      pending_words.push_back(w);
    end
  endtask

  initial begin
    word_t w;
    // single jobs at the extremes
    w = '{du: '0, dl: '0, last: 1'b1};                              pending_words.push_back(w);
    w = '{du: 31'h7fffffff, dl: 31'h7fffffff, last: 1'b1};          pending_words.push_back(w);
    w = '{du: 31'h7fffffff, dl: 31'h7ffffffe, last: 1'b1};          pending_words.push_back(w);
    w = '{du: 31'h7fffffff, dl: '0, last: 1'b1};                    pending_words.push_back(w);
    // replacement of the longest job, three jobs sharing a deadline
    w = '{du: 31'd5, dl: 31'd6, last: 1'b0};                        pending_words.push_back(w);
    w = '{du: 31'd2, dl: 31'd6, last: 1'b0};                        pending_words.push_back(w);
    w = '{du: 31'd3, dl: 31'd6, last: 1'b0};                        pending_words.push_back(w);
    w = '{du: 31'd1, dl: 31'd4, last: 1'b1};                        pending_words.push_back(w);
    // large sums near the top of range
    w = '{du: 31'h40000000, dl: 31'h7fffffff, last: 1'b0};          pending_words.push_back(w);
    w = '{du: 31'h40000000, dl: 31'h7fffffff, last: 1'b0};          pending_words.push_back(w);
    w = '{du: 31'h3fffffff, dl: 31'h7fffffff, last: 1'b1};          pending_words.push_back(w);
    w = '{du: 31'h2aaaaaaa, dl: 31'h55555555, last: 1'b1};          pending_words.push_back(w);
    w = '{du: 31'h55555555, dl: 31'h2aaaaaaa, last: 1'b1};          pending_words.push_back(w);
    // overfull batch, last three jobs dropped
    for (int k = 0; k < Cap + 3; k++) begin
      w.du = 31'($urandom_range(0, 30));
      w.dl = 31'($urandom_range(0, 3000));
      w.last = (k == Cap + 2);
      pending_words.push_back(w);
    end
    for (int b = 0; b < 80; b++)
      add_batch($urandom_range(1, 12), $urandom_range(0, 3));
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 5300 && cycles < 5900)
      calm <= 1'b1;
    else
      calm <= 1'b0;
    if (cycles == 2100)
      hold_off <= 3000;
    else if (hold_off > 0)
      hold_off <= hold_off - 1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        record_job('{du: duration, dl: deadline, last: last_job});
        void'(pending_words.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          word_t w;
          w = pending_words[0];
          in_valid <= 1'b1;
          duration <= w.du;
          deadline <= w.dl;
          last_job <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result jobs_done=%0d overflowed=%0b",
                   $time, jobs_done, overflowed);
          errors++;
        end else begin
          tally_t t;
          t = expected_tallies.pop_front();
          if (jobs_done !== t.done) begin
            $display("%0t: jobs_done expected %0d actual %0d", $time, t.done, jobs_done);
            errors++;
          end
          if (overflowed !== t.ovf) begin
            $display("%0t: overflowed expected %0b actual %0b", $time, t.ovf, overflowed);
            errors++;
          end
        end
      end
      out_ready <= (hold_off == 0) && (calm || $urandom_range(0, 99) >= 22);
    end
  end

  initial begin
    wait (!rst);
    while (pending_words.size() > 0 || in_valid || expected_tallies.size() > 0) begin
      @(posedge clk);
      if (cycles > CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_tallies.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
